### rtl/sha256_byte_stream_hasher_macros.svh
// Assertion helpers for the SHA-256 hasher
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH

// Implication check on the rising edge, off while reset is held
`define SHA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication check
`define SHA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/sha_pkg.sv
`timescale 1ns / 1ps
package sha_pkg;

    localparam int BlockBytes = 64;
    localparam int LenBytePos = 56;
    localparam int Rounds     = 64;
    localparam logic [7:0] PadByte = 8'h80;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } in_word_t;

    typedef struct packed {
        word_t      digest_word;
        logic [2:0] word_index;
        logic       last_word;
    } out_word_t;

    function automatic word_t round_const(input logic [5:0] idx);
        word_t k;
        case (idx)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic word_t init_hash(input logic [2:0] idx);
        word_t h;
        case (idx)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic word_t rotr(input word_t v, input int s);
        return (v >> s) | (v << (32 - s));
    endfunction

endpackage

### rtl/sha_in_if.sv
`timescale 1ns / 1ps
interface sha_in_if;
    import sha_pkg::*;
    logic     valid;
    logic     ready;
    in_word_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/sha_out_if.sv
`timescale 1ns / 1ps
interface sha_out_if;
    import sha_pkg::*;
    logic      valid;
    logic      ready;
    out_word_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/sha256_byte_stream_hasher.sv
// A byte that fills no block is written into the buffer; a byte that fills a block also
//   starts the compression rounds, then a fold into the hash words.
// End of message: padding one byte per cycle between compressions (up to 72 bytes), 1 or 2
//   blocks compressed, then eight digest words, one per cycle as the sink takes them.
// Throughput: one round per cycle in the shared round unit; no byte taken while busy.
// Reset (rst_n, async, active low) loads the initial hash and clears count and length.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher (
    input  logic  clk,
    input  logic  rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);
    import sha_pkg::*;
    `include "sha256_byte_stream_hasher_macros.svh"

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;  // waiting for a word
    localparam logic [2:0] ST_ROUND = 3'd1;  // 64 compression rounds
    localparam logic [2:0] ST_FOLD  = 3'd2;  // add working vars into hash
    localparam logic [2:0] ST_PAD   = 3'd3;  // append pad / length bytes
    localparam logic [2:0] ST_EMIT  = 3'd4;  // present digest words

    logic [2:0]  state_reg, state_next;
    word_t       hash_reg [8];
    // Block buffer held as 16 schedule words; shifts as rounds consume it
    word_t       w_reg [16];
    logic [5:0]  fill_reg;
    logic [60:0] len_reg;
    logic [5:0]  round_reg;
    word_t       a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic        closing_reg;  // compression is part of the padding
    logic [63:0] bits_reg;     // latched bit length for the trailer
    logic [2:0]  emit_reg;

    // Trailer written once a block ends with the length bytes
    logic bits_done_reg;
    logic bits_done;
    assign bits_done = bits_done_reg;

    // Current padding block is the one that carries the length trailer
    logic len_ok_reg;

    // Byte written into the buffer this cycle
    logic        wr_en;
    logic [7:0]  wr_byte;
    logic        accept;

    assign accept       = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = (state_reg == ST_IDLE);

    // Padding byte: 0x80 first, zeros until 56 of the trailer block, then length big-endian
    logic [7:0] pad_byte;
    logic       pad_first_reg;
    always_comb
    begin
        if (pad_first_reg)
        begin
            pad_byte = PadByte;
        end
        else if (len_ok_reg && fill_reg >= 6'(LenBytePos))
        begin
            pad_byte = bits_reg[8*(7 - (fill_reg[2:0])) +: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_byte = in_ch.payload.data_byte;
        if (state_reg == ST_IDLE && accept && in_ch.payload.has_byte)
        begin
            wr_en = 1'b1;
        end
        else if (state_reg == ST_PAD)
        begin
            wr_en   = 1'b1;
            wr_byte = pad_byte;
        end
    end

    // Shared round unit
    word_t s1, ch, t1, s0, mj, t2, ws0, ws1, w_new;
    always_comb
    begin
        s1    = rotr(e_reg, 6) ^ rotr(e_reg, 11) ^ rotr(e_reg, 25);
        ch    = (e_reg & f_reg) ^ (~e_reg & g_reg);
        t1    = h_reg + s1 + ch + round_const(round_reg) + w_reg[0];
        s0    = rotr(a_reg, 2) ^ rotr(a_reg, 13) ^ rotr(a_reg, 22);
        mj    = (a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg);
        t2    = s0 + mj;
        ws0   = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        ws1   = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + ws0 + w_reg[9] + ws1;
    end

    logic block_full;
    assign block_full = wr_en && (fill_reg == 6'(BlockBytes - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (block_full)
                    begin
                        state_next = ST_ROUND;
                    end
                    else if (in_ch.payload.end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND:
            begin
                if (round_reg == 6'(Rounds - 1))
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (closing_reg)
                begin
                    state_next = (fill_reg == 6'd0 && !pad_first_reg && bits_done)
                        ? ST_EMIT : ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD:
            begin
                if (block_full)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_EMIT:
            begin
                if (out_ch.ready && emit_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            len_reg       <= '0;
            round_reg     <= '0;
            closing_reg   <= 1'b0;
            pad_first_reg <= 1'b0;
            bits_done_reg <= 1'b0;
            len_ok_reg    <= 1'b0;
            emit_reg      <= '0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= init_hash(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                fill_reg <= fill_reg + 6'd1;
            end
            if (state_reg == ST_IDLE && accept)
            begin
                if (in_ch.payload.has_byte)
                begin
                    len_reg <= len_reg + 61'd1;
                end
                if (in_ch.payload.end_of_message)
                begin
                    closing_reg   <= 1'b1;
                    pad_first_reg <= 1'b1;
                    bits_done_reg <= 1'b0;
                    // 0x80 lands before byte 56: trailer fits in this block
                    len_ok_reg    <= ((fill_reg + {5'd0, in_ch.payload.has_byte})
                                      < 6'(LenBytePos));
                end
            end
            if (state_reg == ST_PAD)
            begin
                pad_first_reg <= 1'b0;
                if (fill_reg == 6'(BlockBytes - 1))
                begin
                    bits_done_reg <= len_ok_reg;
                    len_ok_reg    <= 1'b1;
                end
            end
            if (state_reg == ST_ROUND)
            begin
                round_reg <= round_reg + 6'd1;
            end
            if (state_reg == ST_FOLD)
            begin
                hash_reg[0] <= hash_reg[0] + a_reg;
                hash_reg[1] <= hash_reg[1] + b_reg;
                hash_reg[2] <= hash_reg[2] + c_reg;
                hash_reg[3] <= hash_reg[3] + d_reg;
                hash_reg[4] <= hash_reg[4] + e_reg;
                hash_reg[5] <= hash_reg[5] + f_reg;
                hash_reg[6] <= hash_reg[6] + g_reg;
                hash_reg[7] <= hash_reg[7] + h_reg;
            end
            if (state_reg == ST_EMIT && out_ch.ready)
            begin
                emit_reg <= emit_reg + 3'd1;
                if (emit_reg == 3'd7)
                begin
                    // Fresh message state
                    closing_reg <= 1'b0;
                    len_reg     <= '0;
                    fill_reg    <= '0;
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_reg[i] <= init_hash(3'(i));
                    end
                end
            end
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept && in_ch.payload.end_of_message)
        begin
            // Length including this word's byte, times eight
            bits_reg <= {len_reg + 61'(in_ch.payload.has_byte), 3'b000};
        end
        if (wr_en)
        begin
            w_reg[fill_reg[5:2]][8*(3 - fill_reg[1:0]) +: 8] <= wr_byte;
        end
        if (block_full)
        begin
            a_reg <= hash_reg[0]; b_reg <= hash_reg[1];
            c_reg <= hash_reg[2]; d_reg <= hash_reg[3];
            e_reg <= hash_reg[4]; f_reg <= hash_reg[5];
            g_reg <= hash_reg[6]; h_reg <= hash_reg[7];
        end
        if (state_reg == ST_ROUND)
        begin
            h_reg <= g_reg; g_reg <= f_reg; f_reg <= e_reg;
            e_reg <= d_reg + t1;
            d_reg <= c_reg; c_reg <= b_reg; b_reg <= a_reg;
            a_reg <= t1 + t2;
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_new;
        end
    end

    assign out_ch.valid               = (state_reg == ST_EMIT);
    assign out_ch.payload.digest_word = hash_reg[emit_reg];
    assign out_ch.payload.word_index  = emit_reg;
    assign out_ch.payload.last_word   = (emit_reg == 3'd7);

    `SHA_ASSERT_IMP(a_ready_idle, in_ch.ready, !out_ch.valid)
    `SHA_ASSERT_NEXT(a_round_to_fold, state_reg == ST_ROUND && round_reg == 6'(Rounds - 1),
        state_reg == ST_FOLD)
    `SHA_ASSERT_IMP(a_emit_closing, out_ch.valid, closing_reg && fill_reg == 6'd0)
    `SHA_ASSERT_NEXT(a_last_wraps, out_ch.valid && out_ch.ready && out_ch.payload.last_word,
        in_ch.ready)

endmodule

### tb/sha256_byte_stream_hasher_tb.sv
`timescale 1ns / 1ps
module sha256_byte_stream_hasher_tb;
    import sha_pkg::*;

    // Digest tracker: mirrors the hasher state and queues the eight expected digest words
    // of every closed message.
    class digest_tracker;
        logic [31:0] hash_st [8];
        logic [7:0]  blk [64];
        logic [5:0]  fill;
        logic [60:0] msg_len;
        out_word_t   pending_words [$];
        int          mismatches;
        int          words_checked;

        function logic [31:0] ror(input logic [31:0] v, input int s);
            return (v >> s) | (v << (32 - s));
        endfunction

        function void restart();
            hash_st[0] = 32'h6a09e667; hash_st[1] = 32'hbb67ae85;
            hash_st[2] = 32'h3c6ef372; hash_st[3] = 32'ha54ff53a;
            hash_st[4] = 32'h510e527f; hash_st[5] = 32'h9b05688c;
            hash_st[6] = 32'h1f83d9ab; hash_st[7] = 32'h5be0cd19;
            fill = '0;
            msg_len = '0;
        endfunction

        function void compress();
            logic [31:0] k [64];
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] t1, t2, s0, s1;
            k = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
                  32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
                  32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
                  32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
                  32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
                  32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
                  32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
                  32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
                  32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
                  32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
                  32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
                  32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
                  32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
            for (int r = 0; r < 16; r++)
                w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
            for (int r = 16; r < 64; r++)
            begin
                s0 = ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3);
                s1 = ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10);
                w[r] = w[r-16] + s0 + w[r-7] + s1;
            end
            v = hash_st;
            for (int r = 0; r < 64; r++)
            begin
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k[r] + w[r];
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int r = 0; r < 8; r++)
                hash_st[r] += v[r];
        endfunction

        function void append(input logic [7:0] b);
            blk[fill] = b;
            fill++;
            if (fill == 0)
                compress();
        endfunction

        // Note one accepted input word.
        function void note_input(input in_word_t w);
            logic [63:0] bitlen;
            out_word_t   o;
            if (w.has_byte)
            begin
                append(w.data_byte);
                msg_len++;
            end
            if (!w.end_of_message)
                return;
            bitlen = {msg_len, 3'b000};
            append(PadByte);
            while (fill != 6'(LenBytePos))
                append(8'h00);
            for (int i = 0; i < 8; i++)
                append(bitlen[63 - 8*i -: 8]);
            for (int i = 0; i < 8; i++)
            begin
                o.digest_word = hash_st[i];
                o.word_index  = 3'(i);
                o.last_word   = (i == 7);
                pending_words.push_back(o);
            end
            restart();
        endfunction

        // Check one accepted digest word against the oldest expectation.
        function void check_output(input out_word_t got);
            out_word_t exp_w;
            words_checked++;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected digest word: got %h/%0d/%0d", $time,
                         got.digest_word, got.word_index, got.last_word);
                mismatches++;
                return;
            end
            exp_w = pending_words.pop_front();
            if (got !== exp_w)
            begin
                $display("%0t: digest mismatch: expected %h/%0d/%0d, got %h/%0d/%0d", $time,
                         exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                         got.digest_word, got.word_index, got.last_word);
                mismatches++;
            end
        endfunction
    endclass

    localparam int WatchdogLimit = 20000;

    logic clk;
    logic rst_n;
    sha_in_if  in_ch ();
    sha_out_if out_ch ();

    sha256_byte_stream_hasher i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    digest_tracker tracker;
    int  send_idle_pct;   // sender idle chance, percent
    int  recv_stall_pct;  // receiver stall chance, percent
    bit  hold_off;        // long receiver hold-off for the pressure test
    int  words_sent;
    int  messages_sent;
    int  idle_cycles;
    bit  timed_out;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Scoreboard hooks and watchdog, sampled at the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                tracker.note_input(in_ch.payload);
            if (out_ch.valid && out_ch.ready)
                tracker.check_output(out_ch.payload);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || tracker.pending_words.size() == 0 && !in_ch.valid)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit && !timed_out)
            begin
                timed_out = 1'b1;
                $display("%0t: watchdog expired", $time);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Offer one word and hold it until taken, with random idle cycles in front.
    // valid stays high after the handshake; the next word replaces it, idle cycles or drain() drop it.
    task automatic send_word(input logic [7:0] b, input logic hb, input logic eom);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= '{data_byte: b, has_byte: hb, end_of_message: eom};
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        words_sent++;
        if (eom)
            messages_sent++;
    endtask

    // Message of n random bytes; the closing byte rides on the end word or not.
    task automatic send_message(input int n);
        bit ride;
        ride = (n > 0) && $urandom_range(1);
        for (int i = 0; i < n - ride; i++)
        begin
            // occasional empty word inside the message
            if ($urandom_range(15) == 0)
                send_word(8'($urandom), 1'b0, 1'b0);
            send_word(8'($urandom), 1'b1, 1'b0);
        end
        send_word(8'($urandom), ride, 1'b1);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    int phase_words;

    initial
    begin
        tracker = new();
        tracker.restart();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        rst_n          = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, idle word, byte extremes, block-boundary sizes
        send_word(8'h00, 1'b0, 1'b1);                  // empty message
        send_word(8'hff, 1'b0, 1'b0);                  // no byte, no end
        send_word(8'h61, 1'b1, 1'b0);                  // "abc"
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);                  // last byte on the end word
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'haa, 1'b0, 1'b1);                  // end without byte
        send_word(8'h55, 1'b1, 1'b1);                  // one-byte message on end word
        send_message(55);                              // padding fits in one block
        send_message(56);                              // padding needs a second block
        send_message(64);                              // exact block
        drain();

        // Random phases with different idle mixes
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1) ? 58 : (ph == 3) ? 32 : 0;
            recv_stall_pct = (ph == 2) ? 58 : (ph == 3) ? 32 : 0;
            phase_words = words_sent;
            while (words_sent - phase_words < 55)
            begin
                case ($urandom_range(9))
                    0: send_word(8'($urandom), 1'($urandom), 1'($urandom));  // noise
                    1: send_message($urandom_range(120));
                    default: send_message($urandom_range(12));
                endcase
            end
            drain();
        end

        // Pressure: receiver holds off while messages keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int m = 0; m < 4; m++)
                    send_message($urandom_range(3));
            end
        join
        drain();

        $display("Covered %0d input words in %0d messages, %0d digest words checked.",
                 words_sent, messages_sent, tracker.words_checked);
        $display("Included empty, block-boundary and long messages under idle and backpressure.");
        if (tracker.mismatches == 0 && tracker.pending_words.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial idle_cycles = 0;
endmodule
